### rtl/trsm_pkg.sv
`timescale 1ns / 1ps
// Package for the touch raw-to-screen map: register indexes, reset values,
// default geometry and the fixed-point reciprocal shift. No dependencies.
package trsm_pkg;

  localparam int unsigned CFG_W           = 12;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned RECIP_SHIFT     = 2 * CFG_W;

  localparam int unsigned DEF_ROW_COUNT   = 320;
  localparam int unsigned DEF_COL_COUNT   = 240;
  localparam int unsigned DEF_SAMPLE_BITS = 12;

  localparam logic [CFG_W-1:0] ROW_MIN_RST = 12'd360;
  localparam logic [CFG_W-1:0] ROW_MAX_RST = 12'd3931;
  localparam logic [CFG_W-1:0] COL_MIN_RST = 12'd158;
  localparam logic [CFG_W-1:0] COL_MAX_RST = 12'd3918;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROWS_FOLLOW_X = 3'd0,
    REG_ROW_INVERTED  = 3'd1,
    REG_ROW_RAW_MIN   = 3'd2,
    REG_ROW_RAW_MAX   = 3'd3,
    REG_COL_INVERTED  = 3'd4,
    REG_COL_RAW_MIN   = 3'd5,
    REG_COL_RAW_MAX   = 3'd6
  } cfg_reg_e;

endpackage

### rtl/touch_raw_to_screen_map.sv
`timescale 1ns / 1ps
// Touch raw-to-screen map: pipelined calibration of raw touch readings to a
// screen row and column. Depends on trsm_pkg.

// Takes one raw X/Y touch reading pair per cycle and returns one screen
// position per item: hit_valid on tuser, screen_row and screen_col on tdata
// (both zero on a miss). A reading is a hit when both driving readings lie
// strictly inside their calibrated ranges and each axis step
// (max - min) / axis size is nonzero. The step is formed by a reciprocal
// multiply and a one-step correction, then (raw - min) / step runs through a
// restoring divider that retires one quotient bit per stage. Items pass the
// input, estimate, product and step registers, the divider stages and the
// output register; throughput is one item per cycle, the whole pipeline
// holding while the output item is not taken. Configuration writes take
// effect on the next edge; write them only while no item is in flight.
module touch_raw_to_screen_map
  import trsm_pkg::*;
#(
  parameter int unsigned ROW_COUNT   = DEF_ROW_COUNT,
  parameter int unsigned COL_COUNT   = DEF_COL_COUNT,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]                 cfg_addr_i,
  input  logic [CFG_W-1:0]                      cfg_wdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // raw_x, raw_y
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // screen_row, screen_col
  output logic [(($clog2(ROW_COUNT+1)+$clog2(COL_COUNT+1)+7)/8)*8-1:0]
                                                m_axis_tdata_o,
  // hit_valid
  output logic                                  m_axis_tuser_o
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned DW     = (SB > CFG_W) ? SB : CFG_W;
  localparam int unsigned ROW_W  = $clog2(ROW_COUNT + 1);
  localparam int unsigned COL_W  = $clog2(COL_COUNT + 1);
  localparam int unsigned OUT_W  = ((ROW_W + COL_W + 7) / 8) * 8;
  localparam int unsigned PROD_W = CFG_W + RECIP_SHIFT + 1;

  localparam logic [CFG_W-1:0] LANE_N [2] = '{CFG_W'(ROW_COUNT), CFG_W'(COL_COUNT)};
  localparam logic [RECIP_SHIFT:0] LANE_M [2] = '{
    (RECIP_SHIFT+1)'((1 << RECIP_SHIFT) / ROW_COUNT),
    (RECIP_SHIFT+1)'((1 << RECIP_SHIFT) / COL_COUNT)
  };

  // configuration
  logic             rows_follow_x_q;
  logic             row_inv_q;
  logic             col_inv_q;
  logic [CFG_W-1:0] row_min_q;
  logic [CFG_W-1:0] row_max_q;
  logic [CFG_W-1:0] col_min_q;
  logic [CFG_W-1:0] col_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_follow_x_q <= 1'b0;
      row_inv_q       <= 1'b0;
      col_inv_q       <= 1'b0;
      row_min_q       <= ROW_MIN_RST;
      row_max_q       <= ROW_MAX_RST;
      col_min_q       <= COL_MIN_RST;
      col_max_q       <= COL_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_ROWS_FOLLOW_X: rows_follow_x_q <= cfg_wdata_i[0];
        REG_ROW_INVERTED:  row_inv_q       <= cfg_wdata_i[0];
        REG_ROW_RAW_MIN:   row_min_q       <= cfg_wdata_i;
        REG_ROW_RAW_MAX:   row_max_q       <= cfg_wdata_i;
        REG_COL_INVERTED:  col_inv_q       <= cfg_wdata_i[0];
        REG_COL_RAW_MIN:   col_min_q       <= cfg_wdata_i;
        REG_COL_RAW_MAX:   col_max_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline registers, lane 0 is the row axis and lane 1 the column axis
  logic             adv;
  logic [SB-1:0]    raw_x;
  logic [SB-1:0]    raw_y;

  logic             a_valid_q;
  logic             a_ok_q    [2];
  logic             a_ok_d    [2];
  logic [DW-1:0]    a_num_q   [2];
  logic [DW-1:0]    a_num_d   [2];
  logic [CFG_W-1:0] a_diff_q  [2];
  logic [CFG_W-1:0] a_diff_d  [2];

  logic             b_valid_q;
  logic             b_ok_q    [2];
  logic [DW-1:0]    b_num_q   [2];
  logic [CFG_W-1:0] b_diff_q  [2];
  logic [CFG_W-1:0] b_qe_q    [2];
  logic [CFG_W-1:0] b_qe_d    [2];

  logic             c_valid_q;
  logic             c_ok_q    [2];
  logic [DW-1:0]    c_num_q   [2];
  logic [CFG_W-1:0] c_diff_q  [2];
  logic [CFG_W-1:0] c_qe_q    [2];
  logic [CFG_W-1:0] c_prod_q  [2];
  logic [CFG_W-1:0] c_prod_d  [2];

  logic             dv_valid_q [DW+1];
  logic             dv_ok_q    [DW+1][2];
  logic             dv_ok_d    [DW+1][2];
  logic [DW-1:0]    dv_num_q   [DW+1][2];
  logic [DW-1:0]    dv_num_d   [DW+1][2];
  logic [CFG_W-1:0] dv_step_q  [DW+1][2];
  logic [CFG_W-1:0] dv_step_d  [DW+1][2];
  logic [CFG_W-1:0] dv_rem_q   [DW+1][2];
  logic [CFG_W-1:0] dv_rem_d   [DW+1][2];
  logic [DW-1:0]    dv_quo_q   [DW+1][2];
  logic [DW-1:0]    dv_quo_d   [DW+1][2];

  logic             out_valid_q;
  logic             out_hit_q;
  logic             out_hit_d;
  logic [ROW_W-1:0] out_row_q;
  logic [ROW_W-1:0] out_row_d;
  logic [COL_W-1:0] out_col_q;
  logic [COL_W-1:0] out_col_d;
  logic [DW-1:0]    pos       [2];

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign raw_x           = s_axis_tdata_i[SB-1:0];
  assign raw_y           = s_axis_tdata_i[2*SB-1:SB];

  always_comb begin
    logic [SB-1:0]          src;
    logic [CFG_W-1:0]       lo;
    logic [CFG_W-1:0]       hi;
    logic [DW-1:0]          src_w;
    logic [DW-1:0]          lo_w;
    logic [DW-1:0]          hi_w;
    logic [PROD_W-1:0]      prod;
    logic [2*CFG_W-1:0]     prod_n;
    logic [CFG_W-1:0]       rem;
    logic [CFG_W-1:0]       step;
    logic [CFG_W:0]         trial;
    logic [DW-1:0]          q;
    logic [DW-1:0]          nq;
    logic                   inv;
    for (int l = 0; l < 2; l++) begin
      // select source and range
      if (l == 0) begin
        src = rows_follow_x_q ? raw_x : raw_y;
        lo  = row_min_q;
        hi  = row_max_q;
        inv = row_inv_q;
      end else begin
        src = rows_follow_x_q ? raw_y : raw_x;
        lo  = col_min_q;
        hi  = col_max_q;
        inv = col_inv_q;
      end
      src_w       = DW'(src);
      lo_w        = DW'(lo);
      hi_w        = DW'(hi);
      a_ok_d[l]   = (src_w > lo_w) && (src_w < hi_w);
      a_num_d[l]  = src_w - lo_w;
      a_diff_d[l] = hi - lo;

      // step estimate by reciprocal
      prod      = PROD_W'(a_diff_q[l]) * PROD_W'(LANE_M[l]);
      b_qe_d[l] = prod[RECIP_SHIFT +: CFG_W];

      // back-multiply, estimate is at most one low
      prod_n      = (2*CFG_W)'(b_qe_q[l]) * (2*CFG_W)'(LANE_N[l]);
      c_prod_d[l] = prod_n[CFG_W-1:0];

      // correct step, reject zero step
      rem  = c_diff_q[l] - c_prod_q[l];
      step = (rem >= LANE_N[l]) ? c_qe_q[l] + CFG_W'(1) : c_qe_q[l];
      dv_step_d[0][l] = step;
      dv_ok_d[0][l]   = c_ok_q[l] && (step != '0);
      dv_num_d[0][l]  = c_num_q[l];
      dv_rem_d[0][l]  = '0;
      dv_quo_d[0][l]  = '0;

      // restoring divider, one quotient bit per stage
      for (int k = 0; k < DW; k++) begin
        trial = {dv_rem_q[k][l], dv_num_q[k][l][DW-1-k]};
        if (trial >= {1'b0, dv_step_q[k][l]}) begin
          dv_rem_d[k+1][l] = CFG_W'(trial - {1'b0, dv_step_q[k][l]});
          dv_quo_d[k+1][l] = {dv_quo_q[k][l][DW-2:0], 1'b1};
        end else begin
          dv_rem_d[k+1][l] = trial[CFG_W-1:0];
          dv_quo_d[k+1][l] = {dv_quo_q[k][l][DW-2:0], 1'b0};
        end
        dv_step_d[k+1][l] = dv_step_q[k][l];
        dv_ok_d[k+1][l]   = dv_ok_q[k][l];
        dv_num_d[k+1][l]  = dv_num_q[k][l];
      end

      // clamp and invert
      q      = dv_quo_q[DW][l];
      nq     = DW'(LANE_N[l]);
      q      = (q > nq) ? nq : q;
      pos[l] = inv ? nq - q : q;
    end
    out_hit_d = dv_ok_q[DW][0] && dv_ok_q[DW][1];
    out_row_d = out_hit_d ? pos[0][ROW_W-1:0] : '0;
    out_col_d = out_hit_d ? pos[1][COL_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= DW; k++) begin
        dv_valid_q[k] <= 1'b0;
      end
    end else if (adv) begin
      a_valid_q     <= s_axis_tvalid_i;
      b_valid_q     <= a_valid_q;
      c_valid_q     <= b_valid_q;
      dv_valid_q[0] <= c_valid_q;
      for (int k = 0; k < DW; k++) begin
        dv_valid_q[k+1] <= dv_valid_q[k];
      end
      out_valid_q   <= dv_valid_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        a_ok_q[l]   <= a_ok_d[l];
        a_num_q[l]  <= a_num_d[l];
        a_diff_q[l] <= a_diff_d[l];
        b_ok_q[l]   <= a_ok_q[l];
        b_num_q[l]  <= a_num_q[l];
        b_diff_q[l] <= a_diff_q[l];
        b_qe_q[l]   <= b_qe_d[l];
        c_ok_q[l]   <= b_ok_q[l];
        c_num_q[l]  <= b_num_q[l];
        c_diff_q[l] <= b_diff_q[l];
        c_qe_q[l]   <= b_qe_q[l];
        c_prod_q[l] <= c_prod_d[l];
        for (int k = 0; k <= DW; k++) begin
          dv_ok_q[k][l]   <= dv_ok_d[k][l];
          dv_num_q[k][l]  <= dv_num_d[k][l];
          dv_step_q[k][l] <= dv_step_d[k][l];
          dv_rem_q[k][l]  <= dv_rem_d[k][l];
          dv_quo_q[k][l]  <= dv_quo_d[k][l];
        end
      end
      out_hit_q <= out_hit_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_col_q, out_row_q});
  assign m_axis_tuser_o  = out_hit_q;

endmodule
